### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle property");

// The expression must never be true.
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition");

`else

`define ASSERT_NEXT(label, ante, cons)
`define ASSERT_NEVER(label, expr)

`endif

`endif

### rtl/brb_pkg.sv
// ---------------------------------------------------------------------------
// Byte ring buffer package
// Field widths, function codes and shared types of the byte ring buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int CAP_W  = 11;
    localparam int LEN_W  = 7;
    localparam int DATA_W = 8;

    localparam int DEFAULT_DEPTH    = 1024;
    localparam int DEFAULT_MAX_READ = 64;

    localparam logic [CAP_W-1:0] COUNT_MAX = 11'd2047;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Access request to the byte store.
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

    // Result fields apart from the byte itself, which comes from the store.
    typedef struct packed {
        logic             strobe;
        logic             data_valid;
        logic             accepted;
        logic [CAP_W-1:0] moved_count;
        logic             last;
        logic [CAP_W-1:0] space_left;
        logic             empty_res;
    } result_t;

endpackage

`default_nettype wire

### rtl/byte_ring_buffer_unit.sv
// ---------------------------------------------------------------------------
// Byte ring buffer unit
// Circular byte buffer with write-call counting and clamped burst reads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// A write item's result is strobed in the next cycle; busy stays low, so
// writes may follow back to back. For a read request of n bytes (after
// clamping to the maximum and to the bytes held), the single-port byte store
// delivers one byte per cycle, busy stays high while the bytes after the
// first are fetched, and each byte is strobed in the cycle after its fetch,
// so results arrive one per cycle starting the cycle after the request.
// Every result is present for exactly one cycle and cannot be held off. The
// store needs no clearing after reset. Writing the capacity register empties
// the buffer and must be done while the unit is idle.
module byte_ring_buffer_unit #(
    parameter int DEPTH    = brb_pkg::DEFAULT_DEPTH,
    parameter int MAX_READ = brb_pkg::DEFAULT_MAX_READ
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [brb_pkg::DATA_W-1:0]    data_in,
    input  wire logic                          end_of_write,
    input  wire logic [brb_pkg::LEN_W-1:0]     read_length,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brb_pkg::CAP_W-1:0]     cfg_data,
    output logic                               strobe,
    output logic      [brb_pkg::DATA_W-1:0]    data_out,
    output logic                               data_valid,
    output logic                               accepted,
    output logic      [brb_pkg::CAP_W-1:0]     moved_count,
    output logic                               last,
    output logic      [brb_pkg::CAP_W-1:0]     space_left,
    output logic                               empty_res
);
    import brb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int XW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
    localparam logic [CAP_W-1:0] RESET_CAP = CAP_W'((DEPTH < 1024) ? DEPTH : 1024);

    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic              cfg_wr;
    mem_ctrl_t         mem_ctrl;
    logic [PTR_W-1:0]  mem_addr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    result_t           res;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Out-of-range capacities are folded into one to the store depth.
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CAP_W'(1);
            end
            else if (XW'(cfg_data) > XW'(DEPTH))
            begin
                cap_next = CAP_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= RESET_CAP;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    brb_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .data_in      (data_in),
        .end_of_write (end_of_write),
        .read_length  (read_length),
        .cfg_clear    (cfg_wr),
        .cap          (cap_reg),
        .mem_ctrl     (mem_ctrl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .res          (res)
    );

    brb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .mem_ctrl (mem_ctrl),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata)
    );

    // The read byte and the result fields are both registered, so they line up.
    assign strobe      = res.strobe;
    assign data_out    = res.data_valid ? mem_rdata : '0;
    assign data_valid  = res.data_valid;
    assign accepted    = res.accepted;
    assign moved_count = res.moved_count;
    assign last        = res.last;
    assign space_left  = res.space_left;
    assign empty_res   = res.empty_res;

    `ASSERT_NEXT(a_write_result, start && !busy && (func == FUNC_WRITE), strobe && !data_valid)
    `ASSERT_NEXT(a_read_result, start && !busy && (func == FUNC_READ), strobe)
    `ASSERT_NEXT(a_burst_result, busy, strobe && data_valid)
    `ASSERT_NEVER(a_read_not_accepted, strobe && data_valid && accepted)

endmodule

`default_nettype wire

### rtl/brb_store.sv
// ---------------------------------------------------------------------------
// Byte store
// Single-port synchronous byte memory with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brb_store #(
    parameter int DEPTH = brb_pkg::DEFAULT_DEPTH
) (
    input  wire logic                          clk,
    input  wire brb_pkg::mem_ctrl_t            mem_ctrl,
    input  wire logic [$clog2(DEPTH)-1:0]      addr,
    input  wire logic [brb_pkg::DATA_W-1:0]    wdata,
    output logic      [brb_pkg::DATA_W-1:0]    rdata
);
    import brb_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctrl.we)
        begin
            mem[addr] <= wdata;
        end
        else if (mem_ctrl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/brb_ctrl.sv
// ---------------------------------------------------------------------------
// Byte ring buffer control
// Pointers, wrap flag, write call count and the read sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brb_ctrl #(
    parameter int DEPTH    = brb_pkg::DEFAULT_DEPTH,
    parameter int MAX_READ = brb_pkg::DEFAULT_MAX_READ
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [brb_pkg::DATA_W-1:0]    data_in,
    input  wire logic                          end_of_write,
    input  wire logic [brb_pkg::LEN_W-1:0]     read_length,
    input  wire logic                          cfg_clear,
    input  wire logic [brb_pkg::CAP_W-1:0]     cap,
    output brb_pkg::mem_ctrl_t                 mem_ctrl,
    output logic      [$clog2(DEPTH)-1:0]      mem_addr,
    output logic      [brb_pkg::DATA_W-1:0]    mem_wdata,
    output brb_pkg::result_t                   res
);
    import brb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int XW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
    localparam int CNT_W = $clog2(MAX_READ + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic              wrap_reg, wrap_next;
    logic [CAP_W-1:0]  call_reg, call_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CAP_W-1:0]  fin_free_reg, fin_free_next;
    logic              fin_empty_reg, fin_empty_next;
    result_t           res_reg, res_next;

    logic [XW-1:0]     cap_x, rp_x, wp_x, free_x, held_x;
    logic [XW-1:0]     rp_inc_x, wp_inc_x, wr_free_x, rd_free_x;
    logic              is_empty, accept, wr_acc, rd_acc, can_store, issue, reading;
    logic [LEN_W-1:0]  len_cut;
    logic [CNT_W-1:0]  n_comb, cur_k, cur_n, k_inc;
    logic [CAP_W-1:0]  call_after;
    logic              rd_fin_empty;

    always_comb
    begin
        cap_x  = XW'(cap);
        rp_x   = XW'(rp_reg);
        wp_x   = XW'(wp_reg);
        free_x = wrap_reg ? (rp_x - wp_x) : (cap_x - wp_x + rp_x);
        held_x = cap_x - free_x;
        is_empty = (rp_reg == wp_reg) && !wrap_reg;

        reading = (state_reg == ST_READ);
        accept  = start && !reading;
        wr_acc  = accept && (func == FUNC_WRITE);
        rd_acc  = accept && (func == FUNC_READ);
        can_store = (free_x != '0);

        // Clamp the request to the maximum, then to the bytes held.
        len_cut = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
        if (XW'(len_cut) > held_x)
        begin
            n_comb = held_x[CNT_W-1:0];
        end
        else
        begin
            n_comb = len_cut[CNT_W-1:0];
        end
        rd_free_x    = free_x + XW'(n_comb);
        rd_fin_empty = (held_x == XW'(n_comb));
        wr_free_x    = free_x - XW'(can_store);

        // The first byte of a read is fetched in the cycle the request is taken.
        issue = (rd_acc && (n_comb != '0)) || reading;
        cur_k = reading ? k_reg : '0;
        cur_n = reading ? n_reg : n_comb;
        k_inc = cur_k + CNT_W'(1);

        rp_inc_x = rp_x + XW'(1);
        wp_inc_x = wp_x + XW'(1);

        if (can_store && (call_reg != COUNT_MAX))
        begin
            call_after = call_reg + CAP_W'(1);
        end
        else
        begin
            call_after = call_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        wrap_next      = wrap_reg;
        call_next      = call_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        fin_free_next  = fin_free_reg;
        fin_empty_next = fin_empty_reg;
        res_next       = '0;

        if (wr_acc)
        begin
            if (can_store)
            begin
                if (wp_inc_x >= cap_x)
                begin
                    wp_next   = '0;
                    wrap_next = 1'b1;
                end
                else
                begin
                    wp_next = wp_inc_x[PTR_W-1:0];
                end
            end
            call_next            = end_of_write ? '0 : call_after;
            res_next.strobe      = 1'b1;
            res_next.accepted    = can_store;
            res_next.moved_count = call_after;
            res_next.last        = end_of_write;
            res_next.space_left  = wr_free_x[CAP_W-1:0];
            res_next.empty_res   = is_empty && !can_store;
        end

        if (rd_acc && (n_comb == '0))
        begin
            res_next.strobe     = 1'b1;
            res_next.last       = 1'b1;
            res_next.space_left = free_x[CAP_W-1:0];
            res_next.empty_res  = is_empty;
        end

        if (rd_acc)
        begin
            n_next         = n_comb;
            fin_free_next  = rd_free_x[CAP_W-1:0];
            fin_empty_next = rd_fin_empty;
        end

        if (issue)
        begin
            if (rp_inc_x >= cap_x)
            begin
                rp_next   = '0;
                wrap_next = 1'b0;
            end
            else
            begin
                rp_next = rp_inc_x[PTR_W-1:0];
            end
            k_next     = k_inc;
            state_next = (k_inc == cur_n) ? ST_IDLE : ST_READ;
            res_next.strobe      = 1'b1;
            res_next.data_valid  = 1'b1;
            res_next.moved_count = CAP_W'(k_inc);
            res_next.last        = (k_inc == cur_n);
            res_next.space_left  = reading ? fin_free_reg : rd_free_x[CAP_W-1:0];
            res_next.empty_res   = reading ? fin_empty_reg : rd_fin_empty;
        end

        if (cfg_clear)
        begin
            rp_next   = '0;
            wp_next   = '0;
            wrap_next = 1'b0;
            call_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rp_reg    <= '0;
            wp_reg    <= '0;
            wrap_reg  <= 1'b0;
            call_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rp_reg    <= rp_next;
            wp_reg    <= wp_next;
            wrap_reg  <= wrap_next;
            call_reg  <= call_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_free_reg  <= fin_free_next;
        fin_empty_reg <= fin_empty_next;
    end

    always_comb
    begin
        mem_ctrl.we = wr_acc && can_store;
        mem_ctrl.re = issue;
        mem_addr    = mem_ctrl.we ? wp_reg : rp_reg;
        mem_wdata   = data_in;
    end

    assign busy = reading;
    assign res  = res_reg;

endmodule

`default_nettype wire

### bench/byte_ring_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte ring buffer unit testbench
// Drives write calls and burst reads into the ring buffer and predicts every
// strobed result from a copy of the pointers, wrap flag and call counter.
// Directed tests cover the empty, full and oversized cases and the capacity
// register at its extremes. Random traffic runs with the sender idling
// heavily, lightly and not at all.
// ---------------------------------------------------------------------------

module byte_ring_buffer_unit_tb;

    import brb_pkg::*;

    localparam int RING_DEPTH = DEFAULT_DEPTH;
    localparam int READ_MAX   = DEFAULT_MAX_READ;
    localparam int SETTLE     = 4;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              data_valid;
        logic              accepted;
        logic [CAP_W-1:0]  moved;
        logic              last;
        logic [CAP_W-1:0]  space_left;
        logic              empty_res;
    } ring_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic [DATA_W-1:0] data_in;
    logic              end_of_write;
    logic [LEN_W-1:0]  read_length;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CAP_W-1:0]  cfg_data;
    logic              strobe;
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              accepted;
    logic [CAP_W-1:0]  moved_count;
    logic              last;
    logic [CAP_W-1:0]  space_left;
    logic              empty_res;

    // Predicted buffer contents and control state.
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    logic [CAP_W-1:0]  rd_ptr;
    logic [CAP_W-1:0]  wr_ptr;
    logic              wr_wrapped;
    logic [CAP_W-1:0]  call_bytes;
    logic [CAP_W-1:0]  capacity;

    ring_result_t pending_results [$];

    int unsigned send_idle_pct;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned capacity_writes;
    int unsigned mismatch_count;

    byte_ring_buffer_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .data_in      (data_in),
        .end_of_write (end_of_write),
        .read_length  (read_length),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .data_out     (data_out),
        .data_valid   (data_valid),
        .accepted     (accepted),
        .moved_count  (moved_count),
        .last         (last),
        .space_left   (space_left),
        .empty_res    (empty_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [CAP_W-1:0] ring_free();
        if (wr_wrapped)
            return rd_ptr - wr_ptr;
        return capacity - wr_ptr + rd_ptr;
    endfunction

    function automatic logic ring_empty();
        return (rd_ptr == wr_ptr) && !wr_wrapped;
    endfunction

    function automatic void empty_ring();
        rd_ptr     = '0;
        wr_ptr     = '0;
        wr_wrapped = 1'b0;
        call_bytes = '0;
    endfunction

    // Works out the results of one accepted item and queues them in order.
    function automatic void predict_ring_access(input logic f, input logic [DATA_W-1:0] wr_byte,
                                                input logic eow, input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] got [READ_MAX];
        logic [CAP_W-1:0]  held;
        logic [CAP_W-1:0]  n;
        logic              acc;
        logic [CAP_W-1:0]  moved;
        if (f == FUNC_WRITE)
        begin
            acc = 1'b0;
            if (ring_free() != 0)
            begin
                ring_mem[wr_ptr % RING_DEPTH] = wr_byte;
                wr_ptr = wr_ptr + 1'b1;
                if (wr_ptr >= capacity)
                begin
                    wr_ptr     = '0;
                    wr_wrapped = 1'b1;
                end
                acc = 1'b1;
                if (call_bytes < COUNT_MAX)
                    call_bytes = call_bytes + 1'b1;
            end
            moved = call_bytes;
            if (eow)
                call_bytes = '0;
            pending_results.push_back({8'h00, 1'b0, acc, moved, eow, ring_free(), ring_empty()});
        end
        else
        begin
            held = capacity - ring_free();
            n = (len > READ_MAX) ? CAP_W'(READ_MAX) : CAP_W'(len);
            if (n > held)
                n = held;
            if (n == 0)
            begin
                pending_results.push_back({8'h00, 1'b0, 1'b0, 11'd0, 1'b1, ring_free(),
                                           ring_empty()});
                return;
            end
            for (int k = 0; k < n; k++)
            begin
                got[k] = ring_mem[rd_ptr % RING_DEPTH];
                rd_ptr = rd_ptr + 1'b1;
                if (rd_ptr >= capacity)
                begin
                    rd_ptr     = '0;
                    wr_wrapped = 1'b0;
                end
            end
            // Free space and the empty flag are those after the whole burst.
            for (int k = 0; k < n; k++)
                pending_results.push_back({got[k], 1'b1, 1'b0, CAP_W'(k + 1), (k + 1 == n),
                                           ring_free(), ring_empty()});
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : result_check
        ring_result_t want;
        ring_result_t got;
        if (rst_n && strobe)
        begin
            got = {data_out, data_valid, accepted, moved_count, last, space_left, empty_res};
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result data %02h moved %0d free %0d",
                                          data_out, moved_count, space_left));
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want)
                    report_mismatch($sformatf({"result %0d: expected data %02h dv %0d acc %0d ",
                        "moved %0d last %0d free %0d empty %0d, got data %02h dv %0d acc %0d ",
                        "moved %0d last %0d free %0d empty %0d"}, results_checked,
                        want.data, want.data_valid, want.accepted, want.moved, want.last,
                        want.space_left, want.empty_res, got.data, got.data_valid,
                        got.accepted, got.moved, got.last, got.space_left, got.empty_res));
            end
        end
    end

    // Offers one item, possibly after idle cycles, and returns on its transfer.
    task automatic send_item(input logic f, input logic [DATA_W-1:0] wr_byte,
                             input logic eow, input logic [LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct)
        begin
            start       <= 1'b0;
            data_in     <= DATA_W'($urandom);
            read_length <= LEN_W'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        start        <= 1'b1;
        func         <= f;
        data_in      <= wr_byte;
        end_of_write <= eow;
        read_length  <= len;
        do
            @(posedge clk);
        while (busy);
        predict_ring_access(f, wr_byte, eow, len);
        items_sent++;
    endtask

    task automatic wait_for_results();
        int unsigned waited;
        start  <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // Zero behaves as one and anything above the depth as the depth.
        if (value < 1)
            capacity = CAP_W'(1);
        else if (value > RING_DEPTH)
            capacity = CAP_W'(RING_DEPTH);
        else
            capacity = value;
        empty_ring();
        capacity_writes++;
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;
            3:       return 11'd1024;
            4:       return CAP_W'($urandom_range(41, 1023));
            default: return CAP_W'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_read_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 7'd0;
        if (r < 18)
            return LEN_W'($urandom_range(65, 127));
        if (r < 26)
            return 7'd64;
        return LEN_W'($urandom_range(1, 16));
    endfunction

    task automatic test_empty_reads();
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd0);
        send_item(FUNC_READ, 8'hFF, 1'b1, 7'd64);
    endtask

    task automatic test_write_calls();
        send_item(FUNC_WRITE, 8'h00, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'hFF, 1'b0, 7'd127);
        send_item(FUNC_WRITE, 8'h5A, 1'b1, 7'd0);
        send_item(FUNC_WRITE, 8'h81, 1'b1, 7'd0);
        // Asks for more than a burst allows; only the four held bytes come out.
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd127);
        send_item(FUNC_WRITE, 8'h01, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'h02, 1'b1, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd1);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd64);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(11'd0);
        send_item(FUNC_WRITE, 8'h11, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'h22, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'h33, 1'b1, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd1);
        write_capacity(11'd2047);
        send_item(FUNC_WRITE, 8'h7E, 1'b1, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd5);
        write_capacity(11'd3);
        send_item(FUNC_WRITE, 8'hA1, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'hA2, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'hA3, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'hA4, 1'b1, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd2);
        send_item(FUNC_WRITE, 8'hB1, 1'b0, 7'd0);
        send_item(FUNC_WRITE, 8'hB2, 1'b1, 7'd0);
        send_item(FUNC_READ, 8'h00, 1'b0, 7'd64);
    endtask

    // Mostly complete write calls and reads, with some stray writes as noise.
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_items);
        int unsigned done_items;
        int unsigned next_setting;
        int unsigned call_len;
        int unsigned pick;
        send_idle_pct = idle_pct;
        done_items    = 0;
        next_setting  = 0;
        while (done_items < n_items)
        begin
            if (done_items >= next_setting)
            begin
                write_capacity(pick_capacity());
                next_setting = next_setting + 31;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                call_len = $urandom_range(1, 6);
                for (int k = 0; k < call_len; k++)
                    send_item(FUNC_WRITE, DATA_W'($urandom), (k == call_len - 1),
                              LEN_W'($urandom));
                done_items = done_items + call_len;
            end
            else if (pick < 90)
            begin
                send_item(FUNC_READ, DATA_W'($urandom), 1'($urandom), pick_read_length());
                done_items++;
            end
            else
            begin
                send_item(FUNC_WRITE, DATA_W'($urandom), 1'($urandom_range(1)),
                          LEN_W'($urandom));
                done_items++;
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        func         <= FUNC_WRITE;
        data_in      <= '0;
        end_of_write <= 1'b0;
        read_length  <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        capacity        = CAP_W'(RING_DEPTH);
        send_idle_pct   = 19;
        items_sent      = 0;
        results_checked = 0;
        capacity_writes = 0;
        mismatch_count  = 0;
        empty_ring();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_write_calls();
        test_capacity_extremes();
        test_random_traffic(19, 84);
        test_random_traffic(83, 84);
        test_random_traffic(0, 84);
        wait_for_results();

        $display("Sent %0d items and checked %0d results over %0d capacity settings.",
                 items_sent, results_checked, capacity_writes);
        $display("Result mismatches seen: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
